// ===== src/mcce_pkg.sv =====
// ----------------------------------------------------------------------------
// mcce_pkg
// Shared constants, types and control structs of the exact-group coloring block
// ----------------------------------------------------------------------------
package mcce_pkg;

    localparam int MAX_COLORS = 128;
    localparam int MAX_GROUPS = 128;

    localparam int COLOR_W = 8;
    localparam int GROUP_W = 8;
    localparam int PAINT_W = 32;
    localparam int TOTAL_W = 40;
    localparam int COST_W  = TOTAL_W + 1;
    localparam int CIDX_W  = $clog2(MAX_COLORS);
    localparam int GIDX_W  = $clog2(MAX_GROUPS);
    localparam int REG_W   = 8;

    localparam logic [COST_W-1:0]  INF_COST   = {1'b1, {TOTAL_W{1'b0}}};
    localparam logic [TOTAL_W-1:0] MAX_FINITE = {TOTAL_W{1'b1}};

    localparam logic [REG_W-1:0] REG_NUM_COLORS    = REG_W'(0);
    localparam logic [REG_W-1:0] REG_TARGET_GROUPS = REG_W'(1);

    typedef struct packed {
        logic [COST_W-1:0]  best;
        logic [COLOR_W-1:0] color;
        logic [COST_W-1:0]  second;
    } best_entry_t;

    typedef struct packed {
        logic               issue;
        logic [GIDX_W-1:0]  g_idx;
        logic [CIDX_W-1:0]  c_idx;
        logic [COLOR_W-1:0] color;
        logic [PAINT_W-1:0] cost;
        logic               pb;
        logic               prev_tab_ok;
        logic               next_tab_ok;
        logic               prev_best_ok;
        logic               next_best_ok;
        logic               first;
        logic               rd_target;
        logic [GIDX_W-1:0]  tg_idx;
    } store_ctrl_t;

    typedef struct packed {
        logic              busy;
        logic [COST_W-1:0] result_best;
    } store_stat_t;

endpackage

// ===== src/mcce_if.sv =====
// ----------------------------------------------------------------------------
// mcce channel interfaces
// Valid/ready channels for items, results and register writes
// ----------------------------------------------------------------------------
interface mcce_item_if import mcce_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] precolor;
    logic [COLOR_W-1:0] color;
    logic [PAINT_W-1:0] cost;
    logic               position_end;
    logic               sequence_end;

    modport source (output valid, precolor, color, cost, position_end, sequence_end,
                    input ready);
    modport sink   (input valid, precolor, color, cost, position_end, sequence_end,
                    output ready);
endinterface

interface mcce_result_if import mcce_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [TOTAL_W-1:0] total_cost;
    logic               feasible;

    modport source (output valid, total_cost, feasible, input ready);
    modport sink   (input valid, total_cost, feasible, output ready);
endinterface

interface mcce_cfg_if import mcce_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [REG_W-1:0] index;
    logic [REG_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/mcce_store.sv =====
// ----------------------------------------------------------------------------
// mcce_store
// Cost table and per-group best/second memories with the column update pipe
// ----------------------------------------------------------------------------
module mcce_store import mcce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  store_ctrl_t ctrl,
    output store_stat_t stat
);

    localparam int TAB_AW  = 1 + CIDX_W + GIDX_W;
    localparam int BEST_AW = 1 + GIDX_W;

    logic [COST_W-1:0] tab_mem [2*MAX_COLORS*MAX_GROUPS];
    best_entry_t       best_mem [2*MAX_GROUPS];

    logic [COST_W-1:0] tab_prev_q;
    logic [COST_W-1:0] tab_next_q;
    best_entry_t       best_a_q;
    best_entry_t       best_b_q;

    logic [TAB_AW-1:0]  tab_prev_addr;
    logic [TAB_AW-1:0]  tab_next_addr;
    logic [TAB_AW-1:0]  tab_wr_addr;
    logic [BEST_AW-1:0] best_a_addr;
    logic [BEST_AW-1:0] best_b_addr;
    logic [BEST_AW-1:0] best_wr_addr;

    logic              s1_valid_reg;
    logic [GIDX_W-1:0] s1_g_reg;
    logic              s2_valid_reg;
    logic [GIDX_W-1:0] s2_g_reg;
    logic [COST_W-1:0] s2_val_reg;
    logic [COST_W-1:0] s2_next_reg;
    best_entry_t       s2_best_reg;

    logic [COST_W-1:0] prev_tab;
    logic [COST_W-1:0] other;
    logic [COST_W-1:0] cand;
    logic [COST_W-1:0] sum;
    logic [COST_W-1:0] val;
    logic [COST_W-1:0] next_tab;
    best_entry_t       next_best;
    logic [COST_W-1:0] new_val;
    best_entry_t       upd_best;

    assign tab_prev_addr = {ctrl.pb, ctrl.c_idx, ctrl.g_idx};
    assign tab_next_addr = {~ctrl.pb, ctrl.c_idx, ctrl.g_idx};
    assign tab_wr_addr   = {~ctrl.pb, ctrl.c_idx, s2_g_reg};
    assign best_a_addr   = ctrl.rd_target ? {ctrl.pb, ctrl.tg_idx}
                                          : {ctrl.pb, ctrl.g_idx - 1'b1};
    assign best_b_addr   = {~ctrl.pb, ctrl.g_idx};
    assign best_wr_addr  = {~ctrl.pb, s2_g_reg};

    always_ff @(posedge clk)
    begin
        tab_prev_q <= tab_mem[tab_prev_addr];
        tab_next_q <= tab_mem[tab_next_addr];
        best_a_q   <= best_mem[best_a_addr];
        best_b_q   <= best_mem[best_b_addr];
        if (s2_valid_reg)
        begin
            tab_mem[tab_wr_addr]   <= new_val;
            best_mem[best_wr_addr] <= upd_best;
        end
    end

    // candidate from previous position and the new entry value
    always_comb
    begin
        prev_tab = ctrl.prev_tab_ok ? tab_prev_q : INF_COST;
        other    = INF_COST;
        if (ctrl.prev_best_ok && (s1_g_reg != '0))
        begin
            other = (best_a_q.color == ctrl.color) ? best_a_q.second : best_a_q.best;
        end
        if (ctrl.first)
        begin
            cand = (s1_g_reg == '0) ? '0 : INF_COST;
        end
        else
        begin
            cand = (other < prev_tab) ? other : prev_tab;
        end
        sum = {1'b0, cand[TOTAL_W-1:0]} + COST_W'(ctrl.cost);
        if (cand[TOTAL_W])
        begin
            val = INF_COST;
        end
        else if (sum[TOTAL_W])
        begin
            val = {1'b0, MAX_FINITE};
        end
        else
        begin
            val = sum;
        end
        next_tab = ctrl.next_tab_ok ? tab_next_q : INF_COST;
        if (ctrl.next_best_ok)
        begin
            next_best = best_b_q;
        end
        else
        begin
            next_best = '{best: INF_COST, color: '0, second: INF_COST};
        end
    end

    // entry update and running best/second over colors
    always_comb
    begin
        new_val  = (s2_val_reg < s2_next_reg) ? s2_val_reg : s2_next_reg;
        upd_best = s2_best_reg;
        if (s2_best_reg.color == ctrl.color)
        begin
            upd_best.best = new_val;
        end
        else if (new_val < s2_best_reg.best)
        begin
            upd_best.second = s2_best_reg.best;
            upd_best.best   = new_val;
            upd_best.color  = ctrl.color;
        end
        else if (new_val < s2_best_reg.second)
        begin
            upd_best.second = new_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= ctrl.issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_g_reg    <= ctrl.g_idx;
        s2_g_reg    <= s1_g_reg;
        s2_val_reg  <= val;
        s2_next_reg <= next_tab;
        s2_best_reg <= next_best;
    end

    assign stat.busy        = s1_valid_reg | s2_valid_reg;
    assign stat.result_best = best_a_q.best;

endmodule

// ===== src/min_cost_coloring_exact_groups.sv =====
// ----------------------------------------------------------------------------
// min_cost_coloring_exact_groups
// Least painting cost of a sequence with exactly target_groups color groups
// ----------------------------------------------------------------------------
// usable color item: accept, sweep over all 128 groups, drain of the update pipe
// item with no usable color: accept only; position end adds a bank swap commit
// sequence end adds target read and result load; the load waits for a free output
// the table read-modify-write port sets the sweep rate: one group entry per cycle
// reset: control clears at once; per-bank column valid bits make tables read as
// infinity, so there is no clearing pass
module min_cost_coloring_exact_groups import mcce_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    mcce_item_if.sink     item,
    mcce_result_if.source result,
    mcce_cfg_if.sink      cfg
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SWEEP  = 6'b000010,
        S_DRAIN  = 6'b000100,
        S_COMMIT = 6'b001000,
        S_READ   = 6'b010000,
        S_RESULT = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [COLOR_W-1:0] num_colors_reg;
    logic [GROUP_W-1:0] target_groups_reg;
    logic               pb_reg;
    logic               first_reg;
    logic [1:0][MAX_COLORS-1:0] col_valid_reg;
    logic [1:0]         best_valid_reg;
    logic [GIDX_W-1:0]  g_cnt_reg;
    logic [COLOR_W-1:0] color_reg;
    logic [PAINT_W-1:0] cost_reg;
    logic               pend_reg;
    logic               send_reg;
    logic               out_valid_reg;
    logic [TOTAL_W-1:0] out_cost_reg;
    logic               out_feasible_reg;

    logic               accept;
    logic [COLOR_W-1:0] limit;
    logic               offer;
    logic [CIDX_W-1:0]  c_idx;
    logic               tg_ok;
    logic [COST_W-1:0]  res_best;
    logic               load_out;

    store_ctrl_t ctrl;
    store_stat_t stat;

    assign accept = item.valid && item.ready;
    assign limit  = (num_colors_reg > COLOR_W'(MAX_COLORS)) ? COLOR_W'(MAX_COLORS)
                                                            : num_colors_reg;
    always_comb
    begin
        if (item.precolor != '0)
        begin
            offer = item.precolor <= COLOR_W'(MAX_COLORS);
        end
        else
        begin
            offer = (item.color != '0) && (item.color <= limit);
        end
    end

    assign c_idx    = CIDX_W'(color_reg - 1'b1);
    assign tg_ok    = (target_groups_reg != '0) &&
                      (target_groups_reg <= GROUP_W'(MAX_GROUPS));
    assign res_best = (tg_ok && best_valid_reg[pb_reg]) ? stat.result_best : INF_COST;
    assign load_out = (state_reg == S_RESULT) && (!out_valid_reg || result.ready);

    always_comb
    begin
        ctrl.issue        = (state_reg == S_SWEEP);
        ctrl.g_idx        = g_cnt_reg;
        ctrl.c_idx        = c_idx;
        ctrl.color        = color_reg;
        ctrl.cost         = cost_reg;
        ctrl.pb           = pb_reg;
        ctrl.prev_tab_ok  = col_valid_reg[pb_reg][c_idx];
        ctrl.next_tab_ok  = col_valid_reg[~pb_reg][c_idx];
        ctrl.prev_best_ok = best_valid_reg[pb_reg];
        ctrl.next_best_ok = best_valid_reg[~pb_reg];
        ctrl.first        = first_reg;
        ctrl.rd_target    = (state_reg == S_READ) || (state_reg == S_RESULT);
        ctrl.tg_idx       = GIDX_W'(target_groups_reg - 1'b1);
    end

    mcce_store u_store
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .stat  (stat)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (offer)
                    begin
                        state_next = S_SWEEP;
                    end
                    else if (item.position_end)
                    begin
                        state_next = S_COMMIT;
                    end
                end
            end
            S_SWEEP:
            begin
                if (g_cnt_reg == GIDX_W'(MAX_GROUPS - 1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!stat.busy)
                begin
                    state_next = pend_reg ? S_COMMIT : S_IDLE;
                end
            end
            S_COMMIT:
            begin
                state_next = send_reg ? S_READ : S_IDLE;
            end
            S_READ:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            num_colors_reg    <= COLOR_W'(128);
            target_groups_reg <= GROUP_W'(1);
            pb_reg            <= 1'b0;
            first_reg         <= 1'b1;
            col_valid_reg     <= '0;
            best_valid_reg    <= '0;
            g_cnt_reg         <= '0;
            pend_reg          <= 1'b0;
            send_reg          <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    REG_NUM_COLORS:    num_colors_reg    <= cfg.data;
                    REG_TARGET_GROUPS: target_groups_reg <= cfg.data;
                    default:           ;
                endcase
            end
            if (accept)
            begin
                pend_reg  <= item.position_end;
                send_reg  <= item.sequence_end;
                g_cnt_reg <= '0;
            end
            if (state_reg == S_SWEEP)
            begin
                g_cnt_reg <= g_cnt_reg + 1'b1;
            end
            if ((state_reg == S_DRAIN) && !stat.busy)
            begin
                col_valid_reg[~pb_reg][c_idx] <= 1'b1;
                best_valid_reg[~pb_reg]       <= 1'b1;
            end
            if (state_reg == S_COMMIT)
            begin
                pb_reg                 <= ~pb_reg;
                col_valid_reg[pb_reg]  <= '0;
                best_valid_reg[pb_reg] <= 1'b0;
                first_reg              <= 1'b0;
            end
            if (load_out)
            begin
                out_valid_reg  <= 1'b1;
                col_valid_reg  <= '0;
                best_valid_reg <= '0;
                first_reg      <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            color_reg <= (item.precolor != '0) ? item.precolor : item.color;
            cost_reg  <= (item.precolor != '0) ? '0 : item.cost;
        end
        if (load_out)
        begin
            out_cost_reg     <= res_best[TOTAL_W] ? '0 : res_best[TOTAL_W-1:0];
            out_feasible_reg <= ~res_best[TOTAL_W];
        end
    end

    assign item.ready        = (state_reg == S_IDLE);
    assign cfg.ready         = 1'b1;
    assign result.valid      = out_valid_reg;
    assign result.total_cost = out_cost_reg;
    assign result.feasible   = out_feasible_reg;

`ifndef SYNTHESIS
    a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RESULT))
        else $error("result without target read");

    a_commit_clears_next: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMMIT) |=> (col_valid_reg[~pb_reg] == '0) &&
                                    !best_valid_reg[~pb_reg] && (pb_reg != $past(pb_reg)))
        else $error("next bank not clear after commit");

    a_report_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> first_reg && (col_valid_reg == '0) && (best_valid_reg == '0))
        else $error("state not restarted after report");

    a_drain_idle_store: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !stat.busy)
        else $error("update pipe busy while idle");
`endif

endmodule
